// File: src/scc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_pkg
// Shared geometry, codes and transfer types of the snooping cache controller.
// ---------------------------------------------------------------------------
package scc_pkg;

    // Cache geometry
    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;

    localparam int OFFSET_W = $clog2(LINE_BYTES);
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int TAG_W    = ADDR_BITS - OFFSET_W - SET_BITS;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // Opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SNOOP = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Bus transactions
    localparam logic [2:0] TX_NONE  = 3'd0;
    localparam logic [2:0] TX_RD    = 3'd1;
    localparam logic [2:0] TX_RDX   = 3'd2;
    localparam logic [2:0] TX_UPD   = 3'd3;
    localparam logic [2:0] TX_RDUPD = 3'd4;

    // Coherence states
    localparam logic [2:0] ST_I  = 3'd0;
    localparam logic [2:0] ST_C  = 3'd1;
    localparam logic [2:0] ST_E  = 3'd2;
    localparam logic [2:0] ST_SC = 3'd3;
    localparam logic [2:0] ST_SM = 3'd4;
    localparam logic [2:0] ST_M  = 3'd5;

    // Protocol select
    localparam logic MODE_INV    = 1'b0;
    localparam logic MODE_DRAGON = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic        copies_elsewhere;
        logic [2:0]  snoop_tx;
    } scc_in_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] bus_request;
        logic       evict_writeback;
        logic       flush;
        logic       intervention;
        logic       invalidated;
        logic       memory_access;
        logic [2:0] line_state;
    } scc_out_t;

    // One way of a set row
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             dirty;
        logic [2:0]       coh;
        logic [31:0]      stamp;
    } scc_way_t;

    typedef scc_way_t [NUM_WAYS-1:0] scc_row_t;

    // Write-back bundle from the step logic to the set store
    typedef struct packed {
        logic                en;
        logic [SET_W-1:0]    set;
        scc_row_t            row;
        logic [NUM_WAYS-1:0] valid;
    } scc_wr_t;

endpackage

// File: src/scc_set_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_set_store
// Per-set row memory (tag, dirty, state, stamp) plus per-line valid flops.
// ---------------------------------------------------------------------------
module scc_set_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [scc_pkg::SET_W-1:0]    rd_set,
    output scc_pkg::scc_row_t            rd_row,
    output logic [scc_pkg::NUM_WAYS-1:0] rd_valid,
    input  scc_pkg::scc_wr_t             wr
);
    import scc_pkg::*;

    scc_row_t            mem [NUM_SETS];
    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    scc_row_t            rd_row_reg;
    logic [NUM_WAYS-1:0] rd_valid_reg;

    // Row memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.set] <= wr.row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_set];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            rd_valid_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.set] <= wr.valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_set];
            end
        end
    end

    assign rd_row   = rd_row_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: src/scc_step_logic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_step_logic
// Lookup, victim choice and protocol transitions for one access on one set.
// ---------------------------------------------------------------------------
module scc_step_logic
(
    input  scc_pkg::scc_in_t             item,
    input  logic                         mode,
    input  logic [31:0]                  count,
    input  scc_pkg::scc_row_t            row,
    input  logic [scc_pkg::NUM_WAYS-1:0] valid,
    output scc_pkg::scc_out_t            res,
    output scc_pkg::scc_row_t            row_next,
    output logic [scc_pkg::NUM_WAYS-1:0] valid_next,
    output logic                         write_row,
    output logic [31:0]                  count_next
);
    import scc_pkg::*;

    logic [TAG_W-1:0] tag;
    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic             any_free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [31:0]      oldest;
    logic [WAY_W-1:0] victim;

    assign tag = item.address[OFFSET_W+SET_BITS +: TAG_W];

    // Tag match, first invalid way, and oldest stamp (ties to higher way)
    always_comb
    begin
        found    = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        lru_way  = '0;
        oldest   = row[0].stamp;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && valid[w] && row[w].tag == tag)
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!any_free && !valid[w])
            begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
            if (row[w].stamp <= oldest)
            begin
                lru_way = WAY_W'(w);
                oldest  = row[w].stamp;
            end
        end
        victim = any_free ? free_way : lru_way;
    end

    // Protocol transitions
    always_comb
    begin
        logic [2:0] st;
        logic       rd;
        logic       upd;
        st         = ST_I;
        rd         = (item.snoop_tx == TX_RD) || (item.snoop_tx == TX_RDUPD);
        upd        = (item.snoop_tx == TX_UPD) || (item.snoop_tx == TX_RDUPD);
        res        = '0;
        row_next   = row;
        valid_next = valid;
        write_row  = 1'b0;
        count_next = count;

        case (item.opcode) inside
            OP_SNOOP:
            begin
                if (found)
                begin
                    write_row = 1'b1;
                    res.hit   = 1'b1;
                    st        = row[hit_way].coh;
                    if (mode == MODE_INV)
                    begin
                        if ((item.snoop_tx == TX_RD || item.snoop_tx == TX_RDX) &&
                            (st == ST_M || st == ST_C))
                        begin
                            res.flush       = (st == ST_M);
                            res.invalidated = 1'b1;
                            valid_next[hit_way]     = 1'b0;
                            row_next[hit_way].dirty = 1'b0;
                            st = ST_I;
                        end
                    end
                    else
                    begin
                        if (rd)
                        begin
                            if (st == ST_E)
                            begin
                                st               = ST_SC;
                                res.intervention = 1'b1;
                            end
                            else if (st == ST_SM)
                            begin
                                res.flush = 1'b1;
                            end
                            else if (st == ST_M)
                            begin
                                st               = ST_SM;
                                res.flush        = 1'b1;
                                res.intervention = 1'b1;
                            end
                        end
                        if (upd && st == ST_SM)
                        begin
                            st = ST_SC;
                        end
                    end
                    row_next[hit_way].coh = st;
                    res.line_state        = st;
                end
            end
            OP_READ, OP_WRITE:
            begin
                write_row  = 1'b1;
                count_next = count + 32'd1;
                if (found)
                begin
                    res.hit                 = 1'b1;
                    row_next[hit_way].stamp = count_next;
                    st                      = row[hit_way].coh;
                    if (mode == MODE_INV)
                    begin
                        st = row[hit_way].dirty ? ST_M : ST_C;
                        if (item.opcode == OP_WRITE)
                        begin
                            row_next[hit_way].dirty = 1'b1;
                            st = ST_M;
                        end
                    end
                    else if (item.opcode == OP_WRITE)
                    begin
                        row_next[hit_way].dirty = 1'b1;
                        if (st == ST_SC || st == ST_SM)
                        begin
                            res.bus_request = TX_UPD;
                            st = item.copies_elsewhere ? ST_SM : ST_M;
                        end
                        else if (st == ST_E)
                        begin
                            st = ST_M;
                        end
                    end
                    row_next[hit_way].coh = st;
                end
                else
                begin
                    st = row[victim].coh;
                    res.evict_writeback = valid[victim] && (st == ST_M || st == ST_SM);
                    res.memory_access   = 1'b1;
                    valid_next[victim]     = 1'b1;
                    row_next[victim].tag   = tag;
                    row_next[victim].dirty = (item.opcode == OP_WRITE);
                    row_next[victim].stamp = count_next;
                    if (mode == MODE_INV)
                    begin
                        st              = (item.opcode == OP_WRITE) ? ST_M : ST_C;
                        res.bus_request = (item.opcode == OP_WRITE) ? TX_RDX : TX_RD;
                    end
                    else if (item.opcode == OP_WRITE)
                    begin
                        st              = item.copies_elsewhere ? ST_SM : ST_M;
                        res.bus_request = item.copies_elsewhere ? TX_RDUPD : TX_RD;
                    end
                    else
                    begin
                        st              = item.copies_elsewhere ? ST_SC : ST_E;
                        res.bus_request = TX_RD;
                    end
                    row_next[victim].coh = st;
                end
                res.line_state = st;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// File: src/snooping_coherent_cache_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snooping_coherent_cache_controller
// Tag and coherence state controller of one core's set-associative cache,
// invalidate (M/C/I) or Dragon update protocol.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  item     | item_valid / item_stall    | scc_in_t  (opcode, address, ...)
//  result   | result_valid / result_stall| scc_out_t (hit, bus_request, ...)
//  config   | cfg_we                     | cfg_data  (protocol_mode)
//
// On a transfer the set row is read from the row memory into a register;
// then the row is updated, written back and the result register loaded.
// Items are taken one at a time; a held result stalls the next transfer.
// Reset clears all valid bits at once (no sweep), protocol_mode resets to 1.
// ---------------------------------------------------------------------------
module snooping_coherent_cache_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  scc_pkg::scc_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output scc_pkg::scc_out_t result,
    input  logic              cfg_we,
    input  logic              cfg_data
);
    import scc_pkg::*;

    logic                busy_reg;
    scc_in_t             item_reg;
    logic                mode_reg;
    logic [31:0]         count_reg;
    logic [31:0]         count_next;
    logic                result_valid_reg;
    scc_out_t            result_reg;
    logic                take;
    scc_row_t            rd_row;
    logic [NUM_WAYS-1:0] rd_valid;
    scc_out_t            res;
    scc_row_t            row_next;
    logic [NUM_WAYS-1:0] valid_next;
    logic                write_row;
    scc_wr_t             wr;

    assign item_stall = busy_reg || (result_valid_reg && result_stall);
    assign take       = item_valid && !item_stall;

    scc_set_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (take),
        .rd_set   (SET_W'(item.address[OFFSET_W +: SET_W])),
        .rd_row   (rd_row),
        .rd_valid (rd_valid),
        .wr       (wr)
    );

    scc_step_logic u_step
    (
        .item       (item_reg),
        .mode       (mode_reg),
        .count      (count_reg),
        .row        (rd_row),
        .valid      (rd_valid),
        .res        (res),
        .row_next   (row_next),
        .valid_next (valid_next),
        .write_row  (write_row),
        .count_next (count_next)
    );

    // Write back the updated set row
    always_comb
    begin
        wr.en    = busy_reg && write_row;
        wr.set   = SET_W'(item_reg.address[OFFSET_W +: SET_W]);
        wr.row   = row_next;
        wr.valid = valid_next;
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    // Control, counter, mode and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            mode_reg         <= MODE_DRAGON;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (busy_reg)
            begin
                busy_reg         <= 1'b0;
                count_reg        <= count_next;
                result_reg       <= res;
                result_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: src/scc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_checker
// Port-level checks of the cache controller, bound to the top level.
// ---------------------------------------------------------------------------
module scc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input scc_pkg::scc_out_t result
);
    import scc_pkg::*;

    // Held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // Accepted item is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##2 result_valid)
        else $error("result missing after transfer");

    // One item in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second transfer while busy");

    // A fill is never a hit
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.memory_access |-> !result.hit)
        else $error("fill reported as hit");

endmodule

bind snooping_coherent_cache_controller scc_checker u_scc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: tb/tb_snooping_coherent_cache_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_snooping_coherent_cache_controller
// Self-checking bench: a directed table followed by random phases under both
// protocols. Results of unpinned items are checked against a local model
// of tag, LRU and coherence state, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_snooping_coherent_cache_controller;
    import scc_pkg::*;

    typedef struct {
        logic     cfg;
        logic     mode;
        scc_in_t  stim;
        logic     pinned;
        scc_out_t res;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_stall;
    scc_in_t  item;
    logic     result_valid;
    logic     result_stall;
    scc_out_t result;
    logic     cfg_we;
    logic     cfg_data;

    // Model of the cache state
    logic [TAG_W-1:0] m_tag   [NUM_SETS][NUM_WAYS];
    logic             m_valid [NUM_SETS][NUM_WAYS];
    logic             m_dirty [NUM_SETS][NUM_WAYS];
    logic [2:0]       m_coh   [NUM_SETS][NUM_WAYS];
    logic [31:0]      m_stamp [NUM_SETS][NUM_WAYS];
    logic [31:0]      m_count;
    logic             m_mode;

    scc_out_t expected_results[$];
    logic     pinned;
    scc_out_t pinned_res;
    logic     calm;
    int       errors;
    int       items_done;
    int       results_done;
    row_t     rows[$];

    snooping_coherent_cache_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Model of one access or snoop
    function automatic scc_out_t cache_step(scc_in_t x);
        scc_out_t         o;
        logic [5:0]       s;
        logic [TAG_W-1:0] t;
        int               w;
        int               v;
        logic [2:0]       st;
        logic [31:0]      oldest;
        logic             rd;
        logic             upd;
        o = '0;
        s = x.address[OFFSET_W +: SET_BITS];
        t = x.address[31 -: TAG_W];
        if (x.opcode == OP_NOP)
            return o;
        w = NUM_WAYS;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
            if (m_valid[s][i] && m_tag[s][i] == t)
                w = i;
        if (x.opcode == OP_SNOOP)
        begin
            if (w == NUM_WAYS)
                return o;
            o.hit = 1'b1;
            st = m_coh[s][w];
            if (m_mode == MODE_INV)
            begin
                if ((x.snoop_tx == TX_RD || x.snoop_tx == TX_RDX) &&
                    (st == ST_M || st == ST_C))
                begin
                    o.flush = (st == ST_M);
                    o.invalidated = 1'b1;
                    m_valid[s][w] = 1'b0;
                    m_dirty[s][w] = 1'b0;
                    st = ST_I;
                end
            end
            else
            begin
                rd  = (x.snoop_tx == TX_RD  || x.snoop_tx == TX_RDUPD);
                upd = (x.snoop_tx == TX_UPD || x.snoop_tx == TX_RDUPD);
                if (rd)
                begin
                    if (st == ST_E)
                    begin
                        st = ST_SC;
                        o.intervention = 1'b1;
                    end
                    else if (st == ST_SM)
                    begin
                        o.flush = 1'b1;
                    end
                    else if (st == ST_M)
                    begin
                        st = ST_SM;
                        o.flush = 1'b1;
                        o.intervention = 1'b1;
                    end
                end
                if (upd && st == ST_SM)
                    st = ST_SC;
            end
            m_coh[s][w] = st;
            o.line_state = st;
            return o;
        end
        m_count = m_count + 32'd1;
        if (w < NUM_WAYS)
        begin
            // hit path
            o.hit = 1'b1;
            m_stamp[s][w] = m_count;
            st = m_coh[s][w];
            if (m_mode == MODE_INV)
            begin
                st = m_dirty[s][w] ? ST_M : ST_C;
                if (x.opcode == OP_WRITE)
                begin
                    m_dirty[s][w] = 1'b1;
                    st = ST_M;
                end
            end
            else if (x.opcode == OP_WRITE)
            begin
                m_dirty[s][w] = 1'b1;
                if (st == ST_SC || st == ST_SM)
                begin
                    o.bus_request = TX_UPD;
                    st = x.copies_elsewhere ? ST_SM : ST_M;
                end
                else if (st == ST_E)
                begin
                    st = ST_M;
                end
            end
        end
        else
        begin
            // miss: invalid way first, else oldest stamp, ties to highest way
            v = NUM_WAYS;
            for (int i = NUM_WAYS - 1; i >= 0; i--)
                if (!m_valid[s][i])
                    v = i;
            if (v == NUM_WAYS)
            begin
                oldest = m_stamp[s][0];
                for (int i = 0; i < NUM_WAYS; i++)
                    if (m_stamp[s][i] <= oldest)
                    begin
                        v = i;
                        oldest = m_stamp[s][i];
                    end
            end
            w = v;
            st = m_coh[s][w];
            o.evict_writeback = m_valid[s][w] && (st == ST_M || st == ST_SM);
            m_tag[s][w] = t;
            m_valid[s][w] = 1'b1;
            m_dirty[s][w] = (x.opcode == OP_WRITE);
            m_stamp[s][w] = m_count;
            o.memory_access = 1'b1;
            if (m_mode == MODE_INV)
            begin
                st = (x.opcode == OP_WRITE) ? ST_M : ST_C;
                o.bus_request = (x.opcode == OP_WRITE) ? TX_RDX : TX_RD;
            end
            else if (x.opcode == OP_WRITE)
            begin
                st = x.copies_elsewhere ? ST_SM : ST_M;
                o.bus_request = x.copies_elsewhere ? TX_RDUPD : TX_RD;
            end
            else
            begin
                st = x.copies_elsewhere ? ST_SC : ST_E;
                o.bus_request = TX_RD;
            end
        end
        m_coh[s][w] = st;
        o.line_state = st;
        return o;
    endfunction

    // Transfer monitor: check results, then record accepted items
    always @(posedge clk)
    begin
        scc_out_t want;
        scc_out_t model;
        if (rst_n && result_valid && !result_stall)
        begin
            results_done++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.hit !== want.hit || result.bus_request !== want.bus_request ||
                    result.evict_writeback !== want.evict_writeback ||
                    result.flush !== want.flush ||
                    result.intervention !== want.intervention ||
                    result.invalidated !== want.invalidated ||
                    result.memory_access !== want.memory_access ||
                    result.line_state !== want.line_state)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, result);
                    errors++;
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            items_done++;
            model = cache_step(item);
            expected_results.push_back(pinned ? pinned_res : model);
        end
    end

    // Receiver idling in bursts
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            n = $urandom_range(1, 14);
            result_stall <= !calm && ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_item(scc_in_t x, logic pin, scc_out_t pres);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 14);
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= x;
        pinned     <= pin;
        pinned_res <= pres;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        m_mode = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t mk(logic c, logic md, logic [1:0] op, logic [31:0] a,
                                logic cp, logic [2:0] tx);
        row_t r;
        r.cfg  = c;
        r.mode = md;
        r.stim = '{opcode: op, address: a, copies_elsewhere: cp, snoop_tx: tx};
        r.pinned = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic scc_in_t rand_item();
        scc_in_t x;
        int      p;
        p = $urandom_range(0, 99);
        x.opcode = (p < 40) ? OP_READ : (p < 68) ? OP_WRITE : (p < 96) ? OP_SNOOP : OP_NOP;
        if ($urandom_range(0, 9) == 0)
            x.address = $urandom;
        else
            x.address = {12'($urandom_range(0, 7)) | ($urandom_range(0, 9) == 0 ?
                         12'hFFF : 12'h0), 8'h0, 6'($urandom_range(0, 3)),
                         6'($urandom)};
        x.copies_elsewhere = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 19);
        x.snoop_tx = (p < 18) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        return x;
    endfunction

    // Hard stop
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        row_t     r;
        scc_out_t e;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        pinned = 1'b0;
        pinned_res = '0;
        calm = 1'b0;
        errors = 0;
        items_done = 0;
        results_done = 0;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                m_valid[s][w] = 1'b0;
                m_dirty[s][w] = 1'b0;
                m_coh[s][w]   = ST_I;
                m_stamp[s][w] = '0;
                m_tag[s][w]   = '0;
            end
        m_count = '0;
        m_mode  = MODE_DRAGON;

        // Directed table: Dragon, then invalidate, then Dragon for the last row
        r = mk(0, 0, OP_READ, 32'h0, 0, TX_NONE);
        r.pinned = 1'b1;
        r.res = '0;
        r.res.bus_request = TX_RD;
        r.res.memory_access = 1'b1;
        r.res.line_state = ST_E;
        rows.push_back(r);
        rows.push_back(mk(0, 0, OP_WRITE, 32'h0000_003F, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0, 1, TX_RD));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0, 0, TX_UPD));
        rows.push_back(mk(0, 0, OP_WRITE, 32'h0, 1, TX_NONE));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0, 0, TX_RDUPD));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0, 0, TX_RDX));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0, 1, 3'd7));
        r = mk(0, 0, OP_NOP, 32'hFFFF_FFFF, 1, 3'd7);
        r.pinned = 1'b1;
        rows.push_back(r);
        rows.push_back(mk(0, 0, OP_WRITE, 32'hFFFF_FFFF, 1, TX_NONE));
        rows.push_back(mk(0, 0, OP_WRITE, 32'h0000_1000, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_READ, 32'h0000_2000, 1, TX_NONE));
        rows.push_back(mk(0, 0, OP_READ, 32'h0000_3000, 1, TX_NONE));
        rows.push_back(mk(0, 0, OP_READ, 32'h0000_4000, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h1234_5678, 0, TX_RD));
        rows.push_back(mk(1, 0, OP_READ, 32'h0000_1000, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_WRITE, 32'h0000_5040, 1, TX_NONE));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0000_5040, 0, TX_UPD));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0000_5040, 0, TX_RD));
        rows.push_back(mk(0, 0, OP_READ, 32'h0000_6080, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_WRITE, 32'h0000_6080, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_READ, 32'h0000_7080, 0, TX_NONE));
        rows.push_back(mk(0, 0, OP_SNOOP, 32'h0000_7080, 0, TX_RDX));
        rows.push_back(mk(1, 1, OP_READ, 32'h0000_6080, 1, TX_NONE));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].cfg)
                write_mode(rows[i].mode);
            send_item(rows[i].stim, rows[i].pinned, rows[i].res);
        end

        // Random phases (INV, Dragon, random); last one runs without idling
        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode(ph == 0 ? MODE_INV : ph == 1 ? MODE_DRAGON : 1'($urandom_range(0, 1)));
            if (ph == 5)
                calm = 1'b1;
            e = '0;
            repeat (220)
                send_item(rand_item(), 1'b0, e);
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d item transfers and %0d result transfers under both protocols,",
                 items_done, results_done);
        $display("with hits, LRU evictions, snoops and mode switches; %0d errors", errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
